@@ design/drbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package drbp_pkg;

    // Default sizing of the panel.
    localparam int MAX_ROWS_DEF      = 512;
    localparam int MAX_ROW_BYTES_DEF = 64;

    // Fixed field widths.
    localparam int BYTE_W    = 8;
    localparam int BPR_W     = 7;
    localparam int GHOST_W   = 4;
    localparam int FULL_W    = 15;
    localparam int ROW_OUT_W = 9;
    localparam int DIFF_W    = 16;
    localparam int KIND_W    = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_ROW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GHOST_LIMIT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_CHANGE_BYTES = 2'd2;

    localparam logic [BPR_W-1:0]   BPR_RESET   = 7'd30;
    localparam logic [GHOST_W-1:0] GHOST_RESET = 4'd3;
    localparam logic [FULL_W-1:0]  FULL_RESET  = 15'd4320;

    localparam logic [GHOST_W-1:0] GHOST_SAT = 4'd15;
    localparam logic [DIFF_W-1:0]  DIFF_SAT  = 16'hFFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 2'd0,
        KIND_PARTIAL = 2'd1,
        KIND_FULL    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [BPR_W-1:0]   bytes_per_row;
        logic [GHOST_W-1:0] ghost_limit;
        logic [FULL_W-1:0]  full_change_bytes;
    } t_cfg;

    // Frame totals including the byte being processed.
    typedef struct packed {
        logic                 any_change;
        logic [ROW_OUT_W-1:0] first_row;
        logic [ROW_OUT_W-1:0] last_row;
        logic [DIFF_W-1:0]    changed_bytes;
    } t_frame_sum;

    typedef struct packed {
        t_kind                kind;
        logic [ROW_OUT_W-1:0] first_row;
        logic [ROW_OUT_W-1:0] last_row;
        logic [DIFF_W-1:0]    changed_bytes;
    } t_result;

endpackage

`default_nettype wire

@@ design/drbp_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module drbp_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [drbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [drbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output drbp_pkg::t_cfg                       o_cfg
);

    drbp_pkg::t_cfg r_cfg;

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_row     <= drbp_pkg::BPR_RESET;
            r_cfg.ghost_limit       <= drbp_pkg::GHOST_RESET;
            r_cfg.full_change_bytes <= drbp_pkg::FULL_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == drbp_pkg::CFG_BYTES_PER_ROW) begin
                r_cfg.bytes_per_row <= i_cfg_data[drbp_pkg::BPR_W-1:0];
            end
            if (i_cfg_idx == drbp_pkg::CFG_GHOST_LIMIT) begin
                r_cfg.ghost_limit <= i_cfg_data[drbp_pkg::GHOST_W-1:0];
            end
            if (i_cfg_idx == drbp_pkg::CFG_FULL_CHANGE_BYTES) begin
                r_cfg.full_change_bytes <= i_cfg_data[drbp_pkg::FULL_W-1:0];
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ design/drbp_frame.sv @@
`timescale 1ns / 1ps
`default_nettype none

module drbp_frame #(
    parameter int MAX_ROWS      = drbp_pkg::MAX_ROWS_DEF,
    parameter int MAX_ROW_BYTES = drbp_pkg::MAX_ROW_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic [drbp_pkg::BYTE_W-1:0] i_new_byte,
    input  wire logic [drbp_pkg::BYTE_W-1:0] i_old_byte,
    input  wire logic                        i_frame_end,
    input  wire logic [drbp_pkg::BPR_W-1:0]  i_bytes_per_row,
    output drbp_pkg::t_frame_sum             o_sum
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int LEN_W = $clog2(MAX_ROW_BYTES + 1);
    localparam int CMP_W = ((LEN_W > drbp_pkg::BPR_W) ? LEN_W : drbp_pkg::BPR_W) + 1;

    localparam logic [CMP_W-1:0] LEN_MAX = CMP_W'(MAX_ROW_BYTES);
    localparam logic [ROW_W-1:0] ROW_TOP = ROW_W'(MAX_ROWS - 1);

    logic [COL_W-1:0]            r_col, n_col;
    logic [ROW_W-1:0]            r_row, n_row;
    logic [ROW_W-1:0]            r_low, n_low;
    logic [ROW_W-1:0]            r_high, n_high;
    logic                        r_any, n_any;
    logic [drbp_pkg::DIFF_W-1:0] r_diff, n_diff;

    logic             differs;
    logic [CMP_W-1:0] bpr_ext;
    logic [CMP_W-1:0] row_len;
    logic [CMP_W-1:0] col_plus;

    always_comb begin
        differs  = (i_new_byte != i_old_byte);
        bpr_ext  = CMP_W'(i_bytes_per_row);
        col_plus = CMP_W'(r_col) + CMP_W'(1);

        // A zero row length acts as one, an oversized one as the maximum.
        if (bpr_ext == '0) begin
            row_len = CMP_W'(1);
        end else if (bpr_ext > LEN_MAX) begin
            row_len = LEN_MAX;
        end else begin
            row_len = bpr_ext;
        end

        n_diff = r_diff;
        n_low  = r_low;
        n_high = r_high;
        if (differs) begin
            if (r_diff != drbp_pkg::DIFF_SAT) begin
                n_diff = r_diff + 1'b1;
            end
            if (!r_any || (r_row < r_low)) begin
                n_low = r_row;
            end
            if (!r_any || (r_row > r_high)) begin
                n_high = r_row;
            end
        end
        n_any = r_any | differs;

        n_row = r_row;
        if (col_plus >= row_len) begin
            n_col = '0;
            if (r_row < ROW_TOP) begin
                n_row = r_row + 1'b1;
            end
        end else begin
            n_col = COL_W'(col_plus);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_low  <= '1;
            r_high <= '0;
            r_any  <= 1'b0;
            r_diff <= '0;
        end else if (i_fire) begin
            if (i_frame_end) begin
                r_col  <= '0;
                r_row  <= '0;
                r_low  <= '1;
                r_high <= '0;
                r_any  <= 1'b0;
                r_diff <= '0;
            end else begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_low  <= n_low;
                r_high <= n_high;
                r_any  <= n_any;
                r_diff <= n_diff;
            end
        end
    end

    assign o_sum.any_change    = n_any;
    assign o_sum.first_row     = drbp_pkg::ROW_OUT_W'(n_low);
    assign o_sum.last_row      = drbp_pkg::ROW_OUT_W'(n_high);
    assign o_sum.changed_bytes = n_diff;

endmodule

`default_nettype wire

@@ design/drbp_policy.sv @@
`timescale 1ns / 1ps
`default_nettype none

module drbp_policy (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_close,
    input  wire drbp_pkg::t_frame_sum          i_sum,
    input  wire logic [drbp_pkg::GHOST_W-1:0]  i_ghost_limit,
    input  wire logic [drbp_pkg::FULL_W-1:0]   i_full_change_bytes,
    output drbp_pkg::t_result                  o_result
);

    logic [drbp_pkg::GHOST_W-1:0] r_ghost, n_ghost;
    logic                         go_full;

    always_comb begin
        go_full = (r_ghost >= i_ghost_limit) ||
                  (i_sum.changed_bytes > drbp_pkg::DIFF_W'(i_full_change_bytes));
        n_ghost = r_ghost;
        o_result.first_row     = i_sum.first_row;
        o_result.last_row      = i_sum.last_row;
        o_result.changed_bytes = i_sum.changed_bytes;

        if (!i_sum.any_change) begin
            o_result.kind          = drbp_pkg::KIND_NONE;
            o_result.first_row     = '0;
            o_result.last_row      = '0;
            o_result.changed_bytes = '0;
        end else if (go_full) begin
            o_result.kind = drbp_pkg::KIND_FULL;
            n_ghost       = '0;
        end else begin
            o_result.kind = drbp_pkg::KIND_PARTIAL;
            if (r_ghost != drbp_pkg::GHOST_SAT) begin
                n_ghost = r_ghost + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ghost <= '0;
        end else if (i_close) begin
            r_ghost <= n_ghost;
        end
    end

endmodule

`default_nettype wire

@@ design/dirty_band_refresh_policy_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Dirty-band refresh policy for an electronic-paper panel. A frame streams in as one
// request per byte, each carrying the new byte, the byte last sent to the panel, and a
// flag on the last byte of the frame. The core counts the bytes that differ, tracks the
// first and last row that hold a difference (rows are found by counting bytes against
// bytes_per_row), and on the flagged byte emits exactly one result: no refresh when
// nothing changed, a full refresh when the ghost counter has reached ghost_limit or the
// change count exceeds full_change_bytes, and a partial band refresh otherwise. Other
// bytes produce no result. The core takes one request per clock cycle unless stalled: a
// request sits in an input register while the frame tracker and the policy logic work
// on it, and a frame-end byte leaving that register writes its result into the output
// register. The only stall comes from the output register: a frame-end byte waits in
// the input register while an earlier result has not been taken. Configuration
// registers are written through a plain write port and must only change while the core
// holds no request and no untaken result.
module dirty_band_refresh_policy_core #(
    parameter int MAX_ROWS      = drbp_pkg::MAX_ROWS_DEF,
    parameter int MAX_ROW_BYTES = drbp_pkg::MAX_ROW_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    input  wire logic                             i_in_valid,
    output wire logic                             o_in_ready,
    input  wire logic [drbp_pkg::BYTE_W-1:0]      i_new_byte,
    input  wire logic [drbp_pkg::BYTE_W-1:0]      i_old_byte,
    input  wire logic                             i_frame_end,

    output wire logic                             o_out_valid,
    input  wire logic                             i_out_ready,
    output wire logic [drbp_pkg::KIND_W-1:0]      o_refresh_kind,
    output wire logic [drbp_pkg::ROW_OUT_W-1:0]   o_first_row,
    output wire logic [drbp_pkg::ROW_OUT_W-1:0]   o_last_row,
    output wire logic [drbp_pkg::DIFF_W-1:0]      o_changed_bytes,

    input  wire logic                             i_cfg_we,
    input  wire logic [drbp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [drbp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    drbp_pkg::t_cfg       cfg;
    drbp_pkg::t_frame_sum sum;
    drbp_pkg::t_result    result;

    // Input register holding the request under work.
    logic                        r_s1_valid, n_s1_valid;
    logic [drbp_pkg::BYTE_W-1:0] r_s1_new;
    logic [drbp_pkg::BYTE_W-1:0] r_s1_old;
    logic                        r_s1_end;

    // Output register holding a finished result.
    logic              r_out_valid, n_out_valid;
    drbp_pkg::t_result r_out;

    logic out_free;
    logic s1_fire;
    logic in_take;
    logic close;

    // The output register can take a new result when it is empty or being drained.
    // A byte that does not close a frame never needs it and always moves on.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && (!r_s1_end || out_free);
    assign close      = s1_fire && r_s1_end;
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_take) begin
            n_s1_valid = 1'b1;
        end else if (s1_fire) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (close) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_new <= i_new_byte;
            r_s1_old <= i_old_byte;
            r_s1_end <= i_frame_end;
        end
        if (close) begin
            r_out <= result;
        end
    end

    drbp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Per-frame accumulation: byte position, changed-row band and change count.
    drbp_frame #(
        .MAX_ROWS      (MAX_ROWS),
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_frame (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (s1_fire),
        .i_new_byte      (r_s1_new),
        .i_old_byte      (r_s1_old),
        .i_frame_end     (r_s1_end),
        .i_bytes_per_row (cfg.bytes_per_row),
        .o_sum           (sum)
    );

    // Refresh decision and the ghost counter that spans frames.
    drbp_policy u_policy (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_close             (close),
        .i_sum               (sum),
        .i_ghost_limit       (cfg.ghost_limit),
        .i_full_change_bytes (cfg.full_change_bytes),
        .o_result            (result)
    );

    assign o_out_valid     = r_out_valid;
    assign o_refresh_kind  = r_out.kind;
    assign o_first_row     = r_out.first_row;
    assign o_last_row      = r_out.last_row;
    assign o_changed_bytes = r_out.changed_bytes;

endmodule

`default_nettype wire

@@ design/drbp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module drbp_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [drbp_pkg::KIND_W-1:0]    o_refresh_kind,
    input wire logic [drbp_pkg::ROW_OUT_W-1:0] o_first_row,
    input wire logic [drbp_pkg::ROW_OUT_W-1:0] o_last_row,
    input wire logic [drbp_pkg::DIFF_W-1:0]    o_changed_bytes
);

    // A result waiting on the output stays valid and keeps its kind and count until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_refresh_kind) && $stable(o_changed_bytes)))
        else $error("result changed while stalled");

    // No result is shown right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A frame without changes reports an empty band and a zero count.
    a_none_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_refresh_kind == drbp_pkg::KIND_NONE)) |->
            ((o_first_row == '0) && (o_last_row == '0) && (o_changed_bytes == '0)))
        else $error("no-refresh result carries data");

    // A refresh implies changed bytes and an ordered band.
    a_band_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_refresh_kind == drbp_pkg::KIND_PARTIAL) ||
                         (o_refresh_kind == drbp_pkg::KIND_FULL))) |->
            ((o_changed_bytes != '0) && (o_first_row <= o_last_row)))
        else $error("refresh result with bad band or count");

    // Only the three defined refresh kinds appear.
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_refresh_kind == drbp_pkg::KIND_NONE) ||
                         (o_refresh_kind == drbp_pkg::KIND_PARTIAL) ||
                         (o_refresh_kind == drbp_pkg::KIND_FULL)))
        else $error("undefined refresh kind");

endmodule

bind dirty_band_refresh_policy_core drbp_checker u_drbp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_refresh_kind  (o_refresh_kind),
    .o_first_row     (o_first_row),
    .o_last_row      (o_last_row),
    .o_changed_bytes (o_changed_bytes)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the dirty-band refresh policy core. Every accepted byte request
// is run through a local predictor. Each frame-end request queues the refresh decision
// the core should make, and every result the core hands out is checked against the
// oldest queued decision, field by field.
module testbench;

    import drbp_pkg::*;

    // Extra cycles give any request still in flight time to settle before a register write.
    localparam int SETTLE_CYCLES = 6;
    localparam int NUM_STEPS     = 23;
    localparam int BLOCK_ITEMS   = 20;

    localparam t_result NO_RESULT = '{KIND_NONE, 9'd0, 9'd0, 16'd0};

    // One row of the directed plan. A row is either a register write or a run of identical
    // byte requests. Rows whose decision is obvious carry it, and that value is queued
    // instead of the predicted one.
    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [BYTE_W-1:0]     new_b;
        logic [BYTE_W-1:0]     old_b;
        logic                  last;
        logic [16:0]           count;
        logic                  pinned;
        t_result               decision;
    } t_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic [BYTE_W-1:0]     i_new_byte = '0;
    logic [BYTE_W-1:0]     i_old_byte = '0;
    logic                  i_frame_end = 1'b0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    wire                   o_in_ready;
    wire                   o_out_valid;
    wire [KIND_W-1:0]      o_refresh_kind;
    wire [ROW_OUT_W-1:0]   o_first_row;
    wire [ROW_OUT_W-1:0]   o_last_row;
    wire [DIFF_W-1:0]      o_changed_bytes;

    // These travel with the request payload, so the accept monitor knows whether a typed-in
    // decision replaces the predicted one.
    logic                  pin_decision = 1'b0;
    t_result               pinned_decision = NO_RESULT;

    // Percent of cycles in which the sender or the receiver holds off.
    int                    send_idle_pct = 18;
    int                    recv_idle_pct = 58;
    int                    n_errors = 0;

    t_result               decision_q[$];
    t_step                 plan[NUM_STEPS];

    // Predictor copy of the registers and of the frame tracker.
    logic [BPR_W-1:0]      cfg_row_bytes = BPR_RESET;
    logic [GHOST_W-1:0]    cfg_ghost_limit = GHOST_RESET;
    logic [FULL_W-1:0]     cfg_full_bytes = FULL_RESET;
    logic [5:0]            cnt_col = '0;
    logic [8:0]            cnt_row = '0;
    logic [8:0]            band_top = 9'h1FF;
    logic [8:0]            band_bottom = '0;
    logic                  seen_change = 1'b0;
    logic [DIFF_W-1:0]     change_total = '0;
    logic [GHOST_W-1:0]    ghost_run = '0;

    dirty_band_refresh_policy_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_new_byte      (i_new_byte),
        .i_old_byte      (i_old_byte),
        .i_frame_end     (i_frame_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_refresh_kind  (o_refresh_kind),
        .o_first_row     (o_first_row),
        .o_last_row      (o_last_row),
        .o_changed_bytes (o_changed_bytes),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Folds one byte request into the predicted frame state. On the frame-end request it
    // returns the refresh decision and starts a fresh frame. The ghost counter survives.
    function automatic void track_request(input logic [BYTE_W-1:0] nb,
                                          input logic [BYTE_W-1:0] ob,
                                          input logic last,
                                          output logic done,
                                          output t_result res);
        int row_len;
        if (cfg_row_bytes == '0) begin
            row_len = 1;
        end else if (int'(cfg_row_bytes) > MAX_ROW_BYTES_DEF) begin
            row_len = MAX_ROW_BYTES_DEF;
        end else begin
            row_len = int'(cfg_row_bytes);
        end
        done = 1'b0;
        res = NO_RESULT;

        // The changed byte belongs to the row in which it arrives, before the count moves on.
        if (nb != ob) begin
            if (change_total != DIFF_SAT) change_total = change_total + 1'b1;
            if (!seen_change || cnt_row < band_top) band_top = cnt_row;
            if (!seen_change || cnt_row > band_bottom) band_bottom = cnt_row;
            seen_change = 1'b1;
        end

        // The row count sticks at the bottom row of the panel.
        if (int'(cnt_col) + 1 >= row_len) begin
            cnt_col = '0;
            if (int'(cnt_row) < MAX_ROWS_DEF - 1) cnt_row = cnt_row + 1'b1;
        end else begin
            cnt_col = cnt_col + 1'b1;
        end

        if (last) begin
            done = 1'b1;
            if (seen_change) begin
                if (ghost_run >= cfg_ghost_limit || change_total > DIFF_W'(cfg_full_bytes)) begin
                    res.kind = KIND_FULL;
                    ghost_run = '0;
                end else begin
                    res.kind = KIND_PARTIAL;
                    if (ghost_run != GHOST_SAT) ghost_run = ghost_run + 1'b1;
                end
                res.first_row = band_top;
                res.last_row = band_bottom;
                res.changed_bytes = change_total;
            end
            cnt_col = '0;
            cnt_row = '0;
            band_top = 9'h1FF;
            band_bottom = '0;
            seen_change = 1'b0;
            change_total = '0;
        end
    endfunction

    // Offers one byte request, idling first at the current sender rate, and returns at the
    // edge where the core takes it. Valid stays high into the next request when there is no
    // gap.
    task automatic send_request(input logic [BYTE_W-1:0] nb, input logic [BYTE_W-1:0] ob,
                                input logic last, input logic pin, input t_result pres);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_new_byte <= nb;
        i_old_byte <= ob;
        i_frame_end <= last;
        pin_decision <= pin;
        pinned_decision <= pres;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stops offering requests and waits until every queued decision has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (decision_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register and mirrors it into the predictor. Only called with the core idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_BYTES_PER_ROW:     cfg_row_bytes = data[BPR_W-1:0];
            CFG_GHOST_LIMIT:       cfg_ghost_limit = data[GHOST_W-1:0];
            CFG_FULL_CHANGE_BYTES: cfg_full_bytes = data[FULL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            n_errors++;
        end
    endtask

    // Accept side: every request the core takes goes through the predictor, and a frame-end
    // request queues its decision.
    always @(posedge i_clk) begin : accept_side
        logic    done;
        t_result res;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            track_request(i_new_byte, i_old_byte, i_frame_end, done, res);
            if (done) decision_q.push_back(pin_decision ? pinned_decision : res);
        end
    end

    // Result side: each result taken must match the oldest queued decision.
    always @(posedge i_clk) begin : result_side
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decision_q.size() == 0) begin
                $display("%0t: result with no request pending, kind %0d rows %0d..%0d count %0d",
                         $time, o_refresh_kind, o_first_row, o_last_row, o_changed_bytes);
                n_errors++;
            end else begin
                want = decision_q.pop_front();
                compare_field("refresh_kind", 32'(want.kind), 32'(o_refresh_kind));
                compare_field("first_row", 32'(want.first_row), 32'(o_first_row));
                compare_field("last_row", 32'(want.last_row), 32'(o_last_row));
                compare_field("changed_bytes", 32'(want.changed_bytes), 32'(o_changed_bytes));
            end
        end
    end

    // The receiver holds off at random at the current rate.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin : stimulus
        int                    frame_len;
        int                    density;
        int                    sent;
        int                    k;
        logic                  paused;
        logic [BYTE_W-1:0]     nb;
        logic [BYTE_W-1:0]     ob;
        logic [CFG_DATA_W-1:0] word;

        // Directed plan. The first rows run from the reset settings: 30 bytes a row, ghost
        // limit 3, full refresh above 4320 changed bytes.
        plan[0]  = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'h5A, 8'h5A, 1'b1, 17'd1, 1'b1,
                     '{KIND_NONE, 9'd0, 9'd0, 16'd0}};
        plan[1]  = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'hFF, 8'h00, 1'b1, 17'd1, 1'b1,
                     '{KIND_PARTIAL, 9'd0, 9'd0, 16'd1}};
        // A frame over three rows with changes in the first two and on the flagged byte.
        plan[2]  = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'h00, 8'hFF, 1'b0, 17'd45, 1'b0, NO_RESULT};
        plan[3]  = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'h12, 8'h12, 1'b0, 17'd20, 1'b0, NO_RESULT};
        plan[4]  = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'h80, 8'h01, 1'b1, 17'd1, 1'b0, NO_RESULT};
        plan[5]  = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'h01, 8'h80, 1'b1, 17'd1, 1'b0, NO_RESULT};
        // Three partial refreshes have built up, so the ghost limit forces a full one.
        plan[6]  = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'h7F, 8'hFE, 1'b1, 17'd1, 1'b1,
                     '{KIND_FULL, 9'd0, 9'd0, 16'd1}};
        // A longer frame with no change at all.
        plan[7]  = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'h33, 8'h33, 1'b0, 17'd10, 1'b0, NO_RESULT};
        plan[8]  = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'hCC, 8'hCC, 1'b1, 17'd1, 1'b1,
                     '{KIND_NONE, 9'd0, 9'd0, 16'd0}};
        // A row length of zero counts as one byte per row.
        plan[9]  = '{1'b1, CFG_BYTES_PER_ROW, 15'd0, 8'h00, 8'h00, 1'b0, 17'd0, 1'b0, NO_RESULT};
        plan[10] = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'hC3, 8'h3C, 1'b0, 17'd3, 1'b0, NO_RESULT};
        plan[11] = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'h00, 8'h00, 1'b0, 17'd4, 1'b0, NO_RESULT};
        plan[12] = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'hAA, 8'h55, 1'b1, 17'd1, 1'b0, NO_RESULT};
        // With a zero ghost limit every changed frame is a full refresh.
        plan[13] = '{1'b1, CFG_GHOST_LIMIT, 15'd0, 8'h00, 8'h00, 1'b0, 17'd0, 1'b0, NO_RESULT};
        plan[14] = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'h01, 8'h02, 1'b1, 17'd1, 1'b1,
                     '{KIND_FULL, 9'd0, 9'd0, 16'd1}};
        // A row length above the maximum counts as the maximum; the threshold drops to zero.
        plan[15] = '{1'b1, CFG_GHOST_LIMIT, 15'd15, 8'h00, 8'h00, 1'b0, 17'd0, 1'b0, NO_RESULT};
        plan[16] = '{1'b1, CFG_BYTES_PER_ROW, 15'd127, 8'h00, 8'h00, 1'b0, 17'd0, 1'b0, NO_RESULT};
        plan[17] = '{1'b1, CFG_FULL_CHANGE_BYTES, 15'd0, 8'h00, 8'h00, 1'b0, 17'd0, 1'b0,
                     NO_RESULT};
        plan[18] = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'h00, 8'h00, 1'b0, 17'd64, 1'b0, NO_RESULT};
        plan[19] = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'h0F, 8'hF0, 1'b1, 17'd1, 1'b0, NO_RESULT};
        // With the threshold at its ceiling, a fully changed frame stays a partial refresh.
        plan[20] = '{1'b1, CFG_FULL_CHANGE_BYTES, 15'd32767, 8'h00, 8'h00, 1'b0, 17'd0, 1'b0,
                     NO_RESULT};
        plan[21] = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'h55, 8'hAA, 1'b0, 17'd40, 1'b0,
                     NO_RESULT};
        plan[22] = '{1'b0, CFG_BYTES_PER_ROW, 15'd0, 8'hAA, 8'h55, 1'b1, 17'd1, 1'b0,
                     NO_RESULT};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_STEPS; r++) begin
            if (plan[r].is_write) begin
                drain_results();
                write_reg(plan[r].reg_idx, plan[r].reg_data);
            end else begin
                repeat (plan[r].count) begin
                    send_request(plan[r].new_b, plan[r].old_b, plan[r].last,
                                 plan[r].pinned, plan[r].decision);
                end
            end
        end

        // Random frames in three phases of idling: the receiver slow, then the sender slow,
        // then both at full rate. Each block starts from fresh register settings, and one
        // block per phase also pauses midway until all results are out.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 18;
                    recv_idle_pct = 58;
                end
                1: begin
                    send_idle_pct = 58;
                    recv_idle_pct = 18;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 4; blk++) begin
                drain_results();

                // Upper data bits beyond each register's width are random on purpose.
                word = CFG_DATA_W'($urandom);
                case ($urandom_range(5))
                    0: word[BPR_W-1:0] = '0;
                    1: word[BPR_W-1:0] = 7'd1;
                    2, 3: word[BPR_W-1:0] = BPR_W'($urandom_range(8, 2));
                    4: word[BPR_W-1:0] = BPR_W'($urandom_range(64, 1));
                    default: word[BPR_W-1:0] = BPR_W'($urandom_range(127, 65));
                endcase
                write_reg(CFG_BYTES_PER_ROW, word);

                word = CFG_DATA_W'($urandom);
                if ($urandom_range(3) == 0) begin
                    word[GHOST_W-1:0] = GHOST_W'($urandom_range(15));
                end else begin
                    word[GHOST_W-1:0] = GHOST_W'($urandom_range(3));
                end
                write_reg(CFG_GHOST_LIMIT, word);

                case ($urandom_range(2))
                    0: word = CFG_DATA_W'($urandom_range(30));
                    1: word = 15'd32767;
                    default: word = CFG_DATA_W'($urandom_range(32767));
                endcase
                write_reg(CFG_FULL_CHANGE_BYTES, word);

                sent = 0;
                paused = 1'b0;
                while (sent < BLOCK_ITEMS) begin
                    if (blk == 2 && !paused && sent >= BLOCK_ITEMS / 2) begin
                        drain_results();
                        paused = 1'b1;
                    end
                    frame_len = ($urandom_range(4) == 0) ? int'($urandom_range(150, 1))
                                                         : int'($urandom_range(24, 1));
                    case ($urandom_range(9))
                        0, 1: density = 0;
                        2, 3: density = 5;
                        9: density = 100;
                        default: density = 50;
                    endcase
                    for (k = 0; k < frame_len; k++) begin
                        nb = BYTE_W'($urandom);
                        if ($urandom_range(99) < density) begin
                            ob = BYTE_W'($urandom);
                            if (ob == nb) ob = ~nb;
                        end else begin
                            ob = nb;
                        end
                        send_request(nb, ob, k == frame_len - 1, 1'b0, NO_RESULT);
                    end
                    sent += frame_len;
                end
            end
        end

        drain_results();
        if (n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #1_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
design/drbp_pkg.sv
design/drbp_cfg.sv
design/drbp_frame.sv
design/drbp_policy.sv
design/dirty_band_refresh_policy_core.sv
design/drbp_checker.sv
tb/sv/testbench.sv
